FILE: rtl/dcd_pkg.sv
// shared constants and the pipeline stage record for the day count to date converter
`default_nettype none

package dcd_pkg;

  // field widths
  localparam int DAY_W   = 22;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int DOY_W   = 9;
  localparam int WDAY_W  = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_W       = YEAR_W + MONTH_W + DOM_W + DOY_W + WDAY_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // calendar constants
  localparam int MAX_DAY_COUNT = 3652058;
  localparam int DAYS_400Y     = 146097;
  localparam int DAYS_100Y     = 36524;
  localparam int DAYS_4Y       = 1461;
  localparam int DAYS_1Y       = 365;
  localparam int DAYS_WEEK     = 7;
  localparam int LAST_4Y_CYCLE = 24;

  // reciprocal estimates: floor(x * M >> S) is the quotient or one less
  localparam int S400   = DAY_W;
  localparam int M400   = (1 << S400) / DAYS_400Y;
  localparam int M400_W = $clog2(M400 + 1);
  localparam int S4     = 16;
  localparam int M4     = (1 << S4) / DAYS_4Y;
  localparam int S7     = DAY_W;
  localparam int M7     = (1 << S7) / DAYS_WEEK;
  localparam int M7_W   = $clog2(M7 + 1);

  localparam int PROD_W  = DAY_W + M400_W;
  localparam int WPROD_W = DAY_W + M7_W;
  localparam int Q_W     = 5;
  localparam int Q1_W    = 2;

  localparam int N_STAGES = 11;

  localparam logic [DOY_W-1:0] MONTH_START_LEAP [0:12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };
  localparam logic [DOY_W-1:0] MONTH_START_COMMON [0:12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [DAY_W-1:0]   rem;
    logic [PROD_W-1:0]  prod;
    logic [DAY_W-1:0]   wk;
    logic [WPROD_W-1:0] wprod;
    logic [Q_W-1:0]     q400;
    logic [Q1_W-1:0]    q100;
    logic [Q_W-1:0]     q4;
    logic [Q1_W-1:0]    q1;
    logic [DOY_W-1:0]   doy0;
    logic               leap;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
    logic [DOY_W-1:0]   doy;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/day_count_to_civil_date_core.sv
// day count to civil date converter, pipelined top level
//
// usage:
//   s_* carries a request: tdata[21:0] is a day count since 0001-01-01 (day zero).
//   counts above 3652058 are treated as 3652058, which is 9999-12-31.
//   m_* carries the date: year, month, day of month, day of year, weekday
//   (0 is sunday) and a leap-year flag.
//   the pipeline has 11 register stages and takes one request every cycle while
//   m_tready is high or no result is waiting. the depth is set by the chain of
//   divisions by 400-year, 100-year, 4-year and 1-year cycle lengths: the 400-year
//   and 4-year ones multiply by a reciprocal and correct by one step, the others
//   compare against multiples of the cycle length, with the month lookup after them.
//   when the receiver holds m_tready low with a result waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
//   rst (synchronous, active high) clears all valid bits; data registers are not
//   reset.
`default_nettype none

module day_count_to_civil_date_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [21:0] day_count, [23:22] zero
  input  wire logic [dcd_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [31:23] day_of_year,
  // [34:32] weekday, [35] leap_year, [39:36] zero
  output logic [dcd_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  localparam int N = dcd_pkg::N_STAGES;
  localparam int DW = dcd_pkg::DAY_W;

  dcd_pkg::stage_t pipe      [N];
  dcd_pkg::stage_t pipe_next [N];
  logic [N-1:0]    valid;
  logic            adv;

  logic [DW-1:0]   din;
  logic [DW-1:0]   dsat;

  assign adv      = !valid[N-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = valid[N-1];

  assign din  = s_tdata[DW-1:0];
  assign dsat = (din > DW'(dcd_pkg::MAX_DAY_COUNT)) ? DW'(dcd_pkg::MAX_DAY_COUNT) : din;

  always_comb begin
    logic [dcd_pkg::MONTH_W-1:0] mcount;
    logic [dcd_pkg::MONTH_W-1:0] midx;
    logic [dcd_pkg::DOY_W-1:0]   mstart;

    mcount = dcd_pkg::MONTH_W'(1);
    midx   = '0;
    mstart = '0;

    for (int k = 1; k < N; k++) begin
      pipe_next[k] = pipe[k-1];
    end

    // saturate, form count + 1 for the weekday path
    pipe_next[0]     = '0;
    pipe_next[0].rem = dsat;
    pipe_next[0].wk  = dsat + DW'(1);

    // reciprocal products
    pipe_next[1].prod  = dcd_pkg::PROD_W'(pipe[0].rem) * dcd_pkg::PROD_W'(dcd_pkg::M400);
    pipe_next[1].wprod = dcd_pkg::WPROD_W'(pipe[0].wk) * dcd_pkg::WPROD_W'(dcd_pkg::M7);

    // quotient estimates and remainders
    pipe_next[2].q400 = dcd_pkg::Q_W'(pipe[1].prod[dcd_pkg::PROD_W-1:dcd_pkg::S400]);
    pipe_next[2].rem  = pipe[1].rem
                        - DW'(dcd_pkg::Q_W'(pipe[1].prod[dcd_pkg::PROD_W-1:dcd_pkg::S400])
                              * dcd_pkg::DAYS_400Y);
    pipe_next[2].wk   = pipe[1].wk
                        - DW'(pipe[1].wprod[dcd_pkg::WPROD_W-1:dcd_pkg::S7] * dcd_pkg::DAYS_WEEK);

    // estimates may be one short
    if (pipe[2].rem >= DW'(dcd_pkg::DAYS_400Y)) begin
      pipe_next[3].rem  = pipe[2].rem - DW'(dcd_pkg::DAYS_400Y);
      pipe_next[3].q400 = pipe[2].q400 + dcd_pkg::Q_W'(1);
    end
    if (pipe[2].wk >= DW'(dcd_pkg::DAYS_WEEK)) begin
      pipe_next[3].wk = pipe[2].wk - DW'(dcd_pkg::DAYS_WEEK);
    end

    // century, last day of a 400-year cycle stays in century 3
    priority if (pipe[3].rem >= DW'(3 * dcd_pkg::DAYS_100Y)) begin
      pipe_next[4].q100 = 2'd3;
      pipe_next[4].rem  = pipe[3].rem - DW'(3 * dcd_pkg::DAYS_100Y);
    end else if (pipe[3].rem >= DW'(2 * dcd_pkg::DAYS_100Y)) begin
      pipe_next[4].q100 = 2'd2;
      pipe_next[4].rem  = pipe[3].rem - DW'(2 * dcd_pkg::DAYS_100Y);
    end else if (pipe[3].rem >= DW'(dcd_pkg::DAYS_100Y)) begin
      pipe_next[4].q100 = 2'd1;
      pipe_next[4].rem  = pipe[3].rem - DW'(dcd_pkg::DAYS_100Y);
    end else begin
      pipe_next[4].q100 = 2'd0;
    end

    pipe_next[5].prod = dcd_pkg::PROD_W'(pipe[4].rem[dcd_pkg::S4-1:0])
                        * dcd_pkg::PROD_W'(dcd_pkg::M4);

    pipe_next[6].q4  = pipe[5].prod[dcd_pkg::S4 +: dcd_pkg::Q_W];
    pipe_next[6].rem = pipe[5].rem
                       - DW'(pipe[5].prod[dcd_pkg::S4 +: dcd_pkg::Q_W] * dcd_pkg::DAYS_4Y);

    if (pipe[6].rem >= DW'(dcd_pkg::DAYS_4Y)) begin
      pipe_next[7].rem = pipe[6].rem - DW'(dcd_pkg::DAYS_4Y);
      pipe_next[7].q4  = pipe[6].q4 + dcd_pkg::Q_W'(1);
    end

    // year in 4-year cycle, last day of the cycle stays in year 3
    priority if (pipe[7].rem >= DW'(3 * dcd_pkg::DAYS_1Y)) begin
      pipe_next[8].q1   = 2'd3;
      pipe_next[8].doy0 = dcd_pkg::DOY_W'(pipe[7].rem - DW'(3 * dcd_pkg::DAYS_1Y));
    end else if (pipe[7].rem >= DW'(2 * dcd_pkg::DAYS_1Y)) begin
      pipe_next[8].q1   = 2'd2;
      pipe_next[8].doy0 = dcd_pkg::DOY_W'(pipe[7].rem - DW'(2 * dcd_pkg::DAYS_1Y));
    end else if (pipe[7].rem >= DW'(dcd_pkg::DAYS_1Y)) begin
      pipe_next[8].q1   = 2'd1;
      pipe_next[8].doy0 = dcd_pkg::DOY_W'(pipe[7].rem - DW'(dcd_pkg::DAYS_1Y));
    end else begin
      pipe_next[8].q1   = 2'd0;
      pipe_next[8].doy0 = dcd_pkg::DOY_W'(pipe[7].rem);
    end
    pipe_next[8].leap = (pipe_next[8].q1 == 2'd3)
                        && (pipe[7].q4 != dcd_pkg::Q_W'(dcd_pkg::LAST_4Y_CYCLE)
                            || pipe[7].q100 == 2'd3);

    pipe_next[9].year = dcd_pkg::YEAR_W'(pipe[8].q400 * 400 + pipe[8].q100 * 100
                                         + pipe[8].q4 * 4 + pipe[8].q1 + 1);
    // month is one plus the number of month starts after january at or below the day
    for (int i = 1; i < 12; i++) begin
      if (pipe[8].doy0 >= (pipe[8].leap ? dcd_pkg::MONTH_START_LEAP[i]
                                        : dcd_pkg::MONTH_START_COMMON[i])) begin
        mcount = mcount + dcd_pkg::MONTH_W'(1);
      end
    end
    pipe_next[9].month = mcount;

    midx   = pipe[9].month - dcd_pkg::MONTH_W'(1);
    mstart = pipe[9].leap ? dcd_pkg::MONTH_START_LEAP[midx]
                          : dcd_pkg::MONTH_START_COMMON[midx];
    pipe_next[10].dom = dcd_pkg::DOM_W'(pipe[9].doy0 - mstart + dcd_pkg::DOY_W'(1));
    pipe_next[10].doy = pipe[9].doy0 + dcd_pkg::DOY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[N-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign m_tdata = {
    (dcd_pkg::OUT_TDATA_W - dcd_pkg::OUT_W)'(0),
    pipe[N-1].leap,
    pipe[N-1].wk[dcd_pkg::WDAY_W-1:0],
    pipe[N-1].doy,
    pipe[N-1].dom,
    pipe[N-1].month,
    pipe[N-1].year
  };

endmodule

`default_nettype wire
